FILE: design/paced_frame_transmit_queue_macros.svh
// assertion macros shared by the paced frame transmit queue modules
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PACED_FRAME_TRANSMIT_QUEUE_MACROS_SVH
`define PACED_FRAME_TRANSMIT_QUEUE_MACROS_SVH

// same-cycle implication, off while reset is low
`define PFTQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define PFTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pftq_pkg.sv
// types and constants of the paced frame transmit queue
// no dependencies; used by every module of the block
package pftq_pkg;

    localparam int unsigned ID_W      = 29;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned PAY_W     = 64;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned HB_W      = 32;
    localparam int unsigned IN_DATA_W = 104;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIV_STEPS = HB_W;
    localparam int unsigned BLINK5_W  = MS_W + 3;

    localparam logic [MS_W-1:0] MS_SAT = '1;

    localparam logic [MS_W-1:0] RST_LONG_INTERVAL  = 16'd50;
    localparam logic [MS_W-1:0] RST_SHORT_INTERVAL = 16'd10;
    localparam logic [MS_W-1:0] RST_ACTIVITY_BLINK = 16'd50;
    localparam logic [MS_W-1:0] RST_HB_BLINK       = 16'd50;
    localparam logic [MS_W-1:0] RST_HB_PERIOD      = 16'd2000;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_TICK    = 2'd1,
        OP_RECEIVE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_INTERVAL  = 3'd0,
        CFG_SHORT_INTERVAL = 3'd1,
        CFG_ACTIVITY_BLINK = 3'd2,
        CFG_HB_BLINK       = 3'd3,
        CFG_HB_PERIOD      = 3'd4,
        CFG_WRITE_ENABLE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DIV  = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic             short_gap;
        logic [PAY_W-1:0] payload;
        logic [LEN_W-1:0] length;
        logic             extended;
        logic [ID_W-1:0]  id;
    } t_frame;

    typedef struct packed {
        logic load;
        logic exec;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

FILE: design/pftq_div.sv
// bit-serial remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle
// depends on pftq_pkg
module pftq_div
    import pftq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [HB_W-1:0] i_dividend,
    input  logic [MS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [MS_W-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [HB_W-1:0]  r_dvd;
    logic [MS_W-1:0]  r_dvs;
    logic [MS_W-1:0]  r_rem;
    logic [MS_W:0]    shifted;
    logic [MS_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[HB_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = MS_W'(shifted - {1'b0, r_dvs});
        end else begin
            n_rem = shifted[MS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HB_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: design/pftq_ctrl.sv
// sequencer of the paced frame transmit queue: accept, execute, divide, deliver
// depends on pftq_pkg and the assertion macro header
`include "paced_frame_transmit_queue_macros.svh"

module pftq_ctrl
    import pftq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait here until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PFTQ_ASSERT_NEXT(a_accept_to_exec, i_in_valid && o_in_ready, r_state == S_EXEC, "accept did not start execution")
    `PFTQ_ASSERT_NEXT(a_exec_to_div, o_cmd.exec, r_state == S_DIV, "execution not followed by divide")
    `PFTQ_ASSERT_NEXT(a_div_holds, r_state == S_DIV && !i_sts.div_done, r_state == S_DIV, "left divide early")
    `PFTQ_ASSERT_SAME(a_load_needs_room, o_cmd.out_load, i_sts.out_free, "result loaded over a held word")

endmodule

FILE: design/pftq_dp.sv
// datapath of the paced frame transmit queue: frame ring, timers, indicators,
// output register; depends on pftq_pkg, pftq_div and the assertion macro header
`include "paced_frame_transmit_queue_macros.svh"

module pftq_dp
    import pftq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    output t_ctrl_sts              o_sts,
    input  logic [IN_DATA_W-1:0]   i_tdata,
    input  logic [OP_W-1:0]        i_tuser,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [MS_W-1:0]        i_cfg_data,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // configuration registers
    logic [MS_W-1:0] r_long_int;
    logic [MS_W-1:0] r_short_int;
    logic [MS_W-1:0] r_act_blink;
    logic [MS_W-1:0] r_hb_blink;
    logic [MS_W-1:0] r_hb_period;
    logic            r_write_en;

    // accepted word
    t_op    r_op;
    t_frame r_frame;
    logic   r_link;

    // queue and timers
    t_frame           r_mem [QUEUE_DEPTH];
    t_frame           r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [MS_W-1:0]  r_since_send;
    logic [MS_W-1:0]  r_since_recv;
    logic [HB_W-1:0]  r_hb;

    // result held across the divide
    logic             r_send;
    t_frame           r_send_frame;
    logic             r_accepted;
    logic             r_full;
    logic             r_send_led;
    logic             r_recv_led;
    logic             r_div_zero;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [MS_W-1:0]  n_since_send;
    logic [MS_W-1:0]  n_since_recv;
    logic [HB_W-1:0]  n_hb;
    logic             n_send;
    logic             n_accepted;
    logic             n_send_led;
    logic             n_recv_led;
    logic             mem_we;
    logic [MS_W-1:0]  gap;
    logic [MS_W-1:0]  divisor;
    logic             div_done;
    logic [MS_W-1:0]  rem;
    logic [HB_W-1:0]  hb_val;
    logic [BLINK5_W-1:0] blink5;
    logic             hb_led;

    assign wr_next = next_slot(r_wr_ptr);
    assign rd_next = next_slot(r_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_int  <= RST_LONG_INTERVAL;
            r_short_int <= RST_SHORT_INTERVAL;
            r_act_blink <= RST_ACTIVITY_BLINK;
            r_hb_blink  <= RST_HB_BLINK;
            r_hb_period <= RST_HB_PERIOD;
            r_write_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_INTERVAL:  r_long_int  <= i_cfg_data;
                CFG_SHORT_INTERVAL: r_short_int <= i_cfg_data;
                CFG_ACTIVITY_BLINK: r_act_blink <= i_cfg_data;
                CFG_HB_BLINK:       r_hb_blink  <= i_cfg_data;
                CFG_HB_PERIOD:      r_hb_period <= i_cfg_data;
                CFG_WRITE_ENABLE:   r_write_en  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op              <= t_op'(i_tuser);
            r_frame.id        <= i_tdata[28:0];
            r_frame.extended  <= i_tdata[29];
            r_frame.length    <= i_tdata[33:30];
            r_frame.payload   <= i_tdata[97:34];
            r_frame.short_gap <= i_tdata[98];
            r_link            <= i_tdata[99];
        end
    end

    // frame ring, read port follows the oldest slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_next] <= r_frame;
        end
        r_rd_data <= r_mem[rd_next];
    end

    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_since_send = r_since_send;
        n_since_recv = r_since_recv;
        n_hb         = r_hb;
        n_send       = 1'b0;
        n_accepted   = 1'b0;
        mem_we       = 1'b0;
        gap          = r_rd_data.short_gap ? r_short_int : r_long_int;
        case (r_op)
            OP_ENQUEUE: begin
                if (wr_next != r_rd_ptr) begin
                    mem_we     = i_cmd.exec;
                    n_wr_ptr   = wr_next;
                    n_accepted = 1'b1;
                end
            end
            OP_TICK: begin
                n_since_send = (r_since_send == MS_SAT) ? MS_SAT : MS_W'(r_since_send + 1'b1);
                n_since_recv = (r_since_recv == MS_SAT) ? MS_SAT : MS_W'(r_since_recv + 1'b1);
                n_hb         = HB_W'(r_hb + 1'b1);
                if (r_wr_ptr != r_rd_ptr && n_since_send >= gap) begin
                    // with writes disabled the frame still leaves the queue
                    n_send       = r_write_en;
                    n_rd_ptr     = rd_next;
                    n_since_send = '0;
                end
            end
            OP_RECEIVE: begin
                n_since_recv = '0;
            end
            default: begin
            end
        endcase
        n_send_led = n_since_send < r_act_blink;
        n_recv_led = n_since_recv < r_act_blink;
        if (n_send_led || n_recv_led) begin
            n_hb = {{(HB_W - MS_W){1'b0}}, r_hb_blink};
        end
        // link down runs the heartbeat at a quarter period
        divisor = r_link ? r_hb_period : {2'b00, r_hb_period[MS_W-1:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_since_send <= MS_SAT;
            r_since_recv <= MS_SAT;
            r_hb         <= '0;
        end else if (i_cmd.exec) begin
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_since_send <= n_since_send;
            r_since_recv <= n_since_recv;
            r_hb         <= n_hb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_send       <= n_send;
            r_send_frame <= n_send ? r_rd_data : '0;
            r_accepted   <= n_accepted;
            r_full       <= next_slot(n_wr_ptr) == n_rd_ptr;
            r_send_led   <= n_send_led;
            r_recv_led   <= n_recv_led;
            r_div_zero   <= divisor == '0;
        end
    end

    pftq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec),
        .i_dividend (n_hb),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    always_comb begin
        hb_val = r_div_zero ? r_hb : {{(HB_W - MS_W){1'b0}}, rem};
        blink5 = BLINK5_W'({r_hb_blink, 2'b00}) + BLINK5_W'(r_hb_blink);
        if (r_link) begin
            hb_led = hb_val < {{(HB_W - MS_W){1'b0}}, r_hb_blink};
        end else begin
            hb_led = hb_val > {{(HB_W - BLINK5_W){1'b0}}, blink5};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {r_recv_led, hb_led, r_send_led, r_full, r_accepted,
                         r_send_frame.payload, r_send_frame.length,
                         r_send_frame.extended, r_send_frame.id, r_send};
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_m_valid || i_m_tready;
    assign o_m_tvalid     = r_m_valid;
    assign o_m_tdata      = r_m_data;

    `PFTQ_ASSERT_SAME(a_ptr_range, 1'b1, r_wr_ptr <= LAST_SLOT && r_rd_ptr <= LAST_SLOT, "queue pointer past last slot")
    `PFTQ_ASSERT_SAME(a_send_on_tick, i_cmd.exec && r_op != OP_TICK, !n_send && n_rd_ptr == r_rd_ptr, "frame left on a non-tick word")
    `PFTQ_ASSERT_NEXT(a_rd_only_exec, !i_cmd.exec, $stable(r_rd_ptr) && $stable(r_wr_ptr), "queue pointer moved outside execution")
    `PFTQ_ASSERT_SAME(a_no_write_full, mem_we, wr_next != r_rd_ptr, "frame written into the kept-empty slot")

endmodule

FILE: design/paced_frame_transmit_queue.sv
// Paced frame transmit queue. Each input word is one operation (enqueue a frame,
// millisecond tick, frame received or none) and gives exactly one output word.
// Frames wait in a ring of QUEUE_DEPTH slots, one slot always kept empty, so up
// to QUEUE_DEPTH-1 frames are held; a tick sends the oldest frame once the time
// since the last send reaches its short or long interval. For each accepted word
// the sequencer executes the operation, lets the bit-serial remainder unit work
// out the heartbeat phase, then hands the result word into the output register.
// Only then is the input ready again, so a new word is not taken before the last
// one reaches the output register; a stalled output holds the sequencer in its
// last step until the held word leaves. A finished word waits in the output
// register while the next input word is already taken. Configuration is written
// through the cfg port, which is always ready, and must only be written while the
// block is idle.
// depends on pftq_pkg, pftq_ctrl, pftq_dp
module paced_frame_transmit_queue
    import pftq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_id, frame_extended, frame_length, frame_payload, short_gap,
    // link_connected, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // send_valid, send_id, send_extended, send_length, send_payload,
    // enqueue_accepted, queue_full, send_led, heartbeat_led, receive_led
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MS_W-1:0]       i_cfg_data
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    assign o_cfg_ready = 1'b1;

    pftq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pftq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
